FILE: design/psg_pkg.sv
// ----------------------------------------------------------------------------
// Phase-shift Green's function package
// Shared types, register indexes and constants for the phase-shift core.
// ----------------------------------------------------------------------------
package psg_pkg;

   localparam int CORDIC_STEPS = 28;
   localparam int ROOT_BITS    = 32;
   localparam int RAD_BITS     = 2 * ROOT_BITS;
   localparam int ANGLE_BITS   = 32;

   // (8/pi) * 2^60, split into upper and lower 32-bit halves.
   localparam logic [31:0] PHASE_C1 = 32'h28BE60DB;
   localparam logic [31:0] PHASE_C0 = 32'h9391054A;

   // Reciprocal of the rotator gain, Q0.30.
   localparam logic [29:0] INV_GAIN = 30'd652032874;

   localparam logic [23:0] SLOWNESS_RESET    = 24'd11185;
   localparam logic [15:0] DEPTH_STEP_RESET  = 16'd2560;
   localparam logic [9:0]  DEPTH_COUNT_RESET = 10'd100;

   typedef enum logic [1:0] {
      CSR_SLOWNESS    = 2'd0,
      CSR_DEPTH_STEP  = 2'd1,
      CSR_DEPTH_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   // Control that travels with each word through the pipeline.
   typedef struct packed {
      logic valid;
      logic evan;
   } tag_type;

   // Arctangent table in units of 2^-32 turn.
   function automatic logic [ANGLE_BITS-1:0] cordic_angle(input int step);
      logic [ANGLE_BITS-1:0] a;
      case (step)
         0:  a = 32'd536870912;
         1:  a = 32'd316933406;
         2:  a = 32'd167458907;
         3:  a = 32'd85004756;
         4:  a = 32'd42667331;
         5:  a = 32'd21354465;
         6:  a = 32'd10679838;
         7:  a = 32'd5340245;
         8:  a = 32'd2670163;
         9:  a = 32'd1335087;
         10: a = 32'd667544;
         11: a = 32'd333772;
         12: a = 32'd166886;
         13: a = 32'd83443;
         14: a = 32'd41722;
         15: a = 32'd20861;
         16: a = 32'd10430;
         17: a = 32'd5215;
         18: a = 32'd2608;
         19: a = 32'd1304;
         20: a = 32'd652;
         21: a = 32'd326;
         22: a = 32'd163;
         23: a = 32'd81;
         24: a = 32'd41;
         25: a = 32'd20;
         26: a = 32'd10;
         27: a = 32'd5;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

FILE: design/psg_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, remainder carried forward; side data rides along.
// ----------------------------------------------------------------------------
module psg_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  psg_pkg::tag_type                   in_tag,
   input  logic [psg_pkg::RAD_BITS-1:0]       in_rad,
   input  logic [SIDE_W-1:0]                  in_side,
   output psg_pkg::tag_type                   out_tag,
   output logic [psg_pkg::ROOT_BITS-1:0]      out_root,
   output logic [SIDE_W-1:0]                  out_side
);

   localparam int N     = psg_pkg::ROOT_BITS;
   localparam int RAD_W = psg_pkg::RAD_BITS;
   localparam int REM_W = N + 1;

   psg_pkg::tag_type   tag_ff  [0:N-1];
   logic [RAD_W-1:0]   rad_ff  [0:N-1];
   logic [REM_W-1:0]   rem_ff  [0:N-1];
   logic [N-1:0]       root_ff [0:N-1];
   logic [SIDE_W-1:0]  side_ff [0:N-1];

   for (genvar k = 0; k < N; k++) begin : g_step
      psg_pkg::tag_type  tag_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [N-1:0]      root_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [REM_W+1:0]  shifted;
      logic [REM_W+1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [N-1:0]      root_in;

      if (k == 0) begin : g_first
         assign tag_prev  = in_tag;
         assign rad_prev  = in_rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign tag_prev  = tag_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         shifted = {rem_prev, rad_prev[RAD_W-1 -: 2]};
         trial   = {1'b0, root_prev, 2'b01};
         if (shifted >= trial) begin
            rem_in  = REM_W'(shifted - trial);
            root_in = {root_prev[N-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(shifted);
            root_in = {root_prev[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (en) begin
            tag_ff[k] <= tag_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_tag  = tag_ff[N-1];
   assign out_root = root_ff[N-1];
   assign out_side = side_ff[N-1];

endmodule

FILE: design/psg_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC rotator
// One micro-rotation per stage on a residual angle in 2^-32 turn units.
// ----------------------------------------------------------------------------
module psg_cordic #(
   parameter int XW = 49
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  psg_pkg::tag_type                      in_tag,
   input  logic signed [XW-1:0]                  in_x,
   input  logic signed [XW-1:0]                  in_y,
   input  logic signed [psg_pkg::ANGLE_BITS-1:0] in_z,
   output psg_pkg::tag_type                      out_tag,
   output logic signed [XW-1:0]                  out_x,
   output logic signed [XW-1:0]                  out_y
);

   localparam int N  = psg_pkg::CORDIC_STEPS;
   localparam int AW = psg_pkg::ANGLE_BITS;

   psg_pkg::tag_type     tag_ff [0:N-1];
   logic signed [XW-1:0] x_ff   [0:N-1];
   logic signed [XW-1:0] y_ff   [0:N-1];
   logic signed [AW-1:0] z_ff   [0:N-1];

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam logic signed [AW-1:0] ANG = psg_pkg::cordic_angle(k);
      psg_pkg::tag_type     tag_prev;
      logic signed [XW-1:0] x_prev;
      logic signed [XW-1:0] y_prev;
      logic signed [AW-1:0] z_prev;
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic signed [XW-1:0] x_in;
      logic signed [XW-1:0] y_in;
      logic signed [AW-1:0] z_in;

      if (k == 0) begin : g_first
         assign tag_prev = in_tag;
         assign x_prev   = in_x;
         assign y_prev   = in_y;
         assign z_prev   = in_z;
      end else begin : g_next
         assign tag_prev = tag_ff[k-1];
         assign x_prev   = x_ff[k-1];
         assign y_prev   = y_ff[k-1];
         assign z_prev   = z_ff[k-1];
      end

      always_comb begin
         dx = y_prev >>> k;
         dy = x_prev >>> k;
         if (!z_prev[AW-1]) begin
            x_in = x_prev - dx;
            y_in = y_prev + dy;
            z_in = z_prev - ANG;
         end else begin
            x_in = x_prev + dx;
            y_in = y_prev - dy;
            z_in = z_prev + ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (en) begin
            tag_ff[k] <= tag_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k] <= x_in;
            y_ff[k] <= y_in;
            z_ff[k] <= z_in;
         end
      end
   end

   assign out_tag = tag_ff[N-1];
   assign out_x   = x_ff[N-1];
   assign out_y   = y_ff[N-1];

endmodule

FILE: design/phase_shift_green_function_core.sv
// ----------------------------------------------------------------------------
// Phase-shift Green's function core
// Vertical wavenumber, two-way phase over the depth grid, and rotation of the
// source sample by that phase.
//
//   Channel  Ports                                   Direction  Flow
//   req      req_valid/req_stall, omega, kx, source  in         valid/stall
//   rsp      rsp_valid/rsp_stall, green, evanescent  out        valid/stall
//   csr      csr_valid/csr_ready, index, data        in         valid/ready
//
// One word enters every cycle unless a stall on rsp holds the pipeline; each
// word passes 70 register stages, ending in the result register. The stages
// are 4 input stages, the 32-stage square root, 5 phase stages, the 28-stage
// rotator and the result register. Reset clears the valid bits and loads the
// register defaults. A stall on rsp holds the whole pipeline; req_stall follows
// it directly. Register writes are always taken; slowness is used from the next
// cycle and the depth settings after the further depth-product register.
// ----------------------------------------------------------------------------
module phase_shift_green_function_core #(
   parameter int DEPTH_MAX   = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [23:0]            req_omega,
   input  logic signed [23:0]            req_wavenumber,
   input  logic signed [SAMPLE_BITS-1:0] req_source_re,
   input  logic signed [SAMPLE_BITS-1:0] req_source_im,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_green_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_green_im,
   output logic                          rsp_evanescent,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [23:0]                   csr_data
);

   localparam int SB    = SAMPLE_BITS;
   localparam int XW    = SB + 25;
   localparam int PW    = SB + 31;
   localparam int N_CAP = (DEPTH_MAX - 1 > 1023) ? 1023 : DEPTH_MAX - 1;
   localparam int RW    = XW - 22;

   // ---------------- configuration ----------------
   logic [23:0] slowness_ff;
   logic [15:0] depth_step_ff;
   logic [9:0]  depth_count_ff;
   logic [9:0]  count_sat;
   logic [26:0] ds2n_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slowness_ff    <= psg_pkg::SLOWNESS_RESET;
         depth_step_ff  <= psg_pkg::DEPTH_STEP_RESET;
         depth_count_ff <= psg_pkg::DEPTH_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (psg_pkg::csr_index_type'(csr_index))
            psg_pkg::CSR_SLOWNESS:    slowness_ff    <= csr_data;
            psg_pkg::CSR_DEPTH_STEP:  depth_step_ff  <= csr_data[15:0];
            psg_pkg::CSR_DEPTH_COUNT: depth_count_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   assign count_sat = (depth_count_ff > 10'(N_CAP)) ? 10'(N_CAP) : depth_count_ff;

   // Depth step times the two-way step count.
   always_ff @(posedge clock) begin
      ds2n_ff <= 27'(depth_step_ff) * 27'({count_sat, 1'b0});
   end

   // ---------------- flow control ----------------
   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // ---------------- stage 1: magnitudes ----------------
   psg_pkg::tag_type       s1_tag_ff;
   logic [23:0]            s1_wm_ff;
   logic [23:0]            s1_km_ff;
   logic                   s1_wpos_ff;
   logic signed [SB-1:0]   s1_x_ff;
   logic signed [SB-1:0]   s1_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
      end else if (en) begin
         s1_tag_ff <= '{valid: req_valid, evan: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_wm_ff   <= req_omega[23] ? 24'(-req_omega) : req_omega;
         s1_km_ff   <= req_wavenumber[23] ? 24'(-req_wavenumber) : req_wavenumber;
         s1_wpos_ff <= !req_omega[23] && (req_omega != '0);
         s1_x_ff    <= req_source_re;
         s1_y_ff    <= req_source_im;
      end
   end

   // ---------------- stage 2: products ----------------
   psg_pkg::tag_type     s2_tag_ff;
   logic [47:0]          s2_pf_ff;
   logic [46:0]          s2_kk_ff;
   logic                 s2_wpos_ff;
   logic signed [XW-1:0] s2_x_ff;
   logic signed [XW-1:0] s2_y_ff;
   logic signed [PW-1:0] x_prod;
   logic signed [PW-1:0] y_prod;

   assign x_prod = PW'(s1_x_ff) * PW'($signed({1'b0, psg_pkg::INV_GAIN}));
   assign y_prod = PW'(s1_y_ff) * PW'($signed({1'b0, psg_pkg::INV_GAIN}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff <= '0;
      end else if (en) begin
         s2_tag_ff <= s1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_pf_ff   <= 48'(s1_wm_ff) * 48'(slowness_ff);
         s2_kk_ff   <= 47'(s1_km_ff) * 47'(s1_km_ff);
         s2_wpos_ff <= s1_wpos_ff;
         s2_x_ff    <= XW'($signed(x_prod[PW-1:8]));
         s2_y_ff    <= XW'($signed(y_prod[PW-1:8]));
      end
   end

   // ---------------- stage 3: square of p ----------------
   psg_pkg::tag_type     s3_tag_ff;
   logic [63:0]          s3_pp_ff;
   logic [46:0]          s3_kk_ff;
   logic                 s3_wpos_ff;
   logic signed [XW-1:0] s3_x_ff;
   logic signed [XW-1:0] s3_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_tag_ff <= '0;
      end else if (en) begin
         s3_tag_ff <= s2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_pp_ff   <= 64'(s2_pf_ff[47:16]) * 64'(s2_pf_ff[47:16]);
         s3_kk_ff   <= s2_kk_ff;
         s3_wpos_ff <= s2_wpos_ff;
         s3_x_ff    <= s2_x_ff;
         s3_y_ff    <= s2_y_ff;
      end
   end

   // ---------------- stage 4: radicand ----------------
   psg_pkg::tag_type     s4_tag_ff;
   logic [63:0]          s4_rad_ff;
   logic                 s4_wpos_ff;
   logic signed [XW-1:0] s4_x_ff;
   logic signed [XW-1:0] s4_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_tag_ff <= '0;
      end else if (en) begin
         s4_tag_ff <= '{valid: s3_tag_ff.valid, evan: (s3_pp_ff <= 64'(s3_kk_ff))};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_rad_ff  <= s3_pp_ff - 64'(s3_kk_ff);
         s4_wpos_ff <= s3_wpos_ff;
         s4_x_ff    <= s3_x_ff;
         s4_y_ff    <= s3_y_ff;
      end
   end

   // ---------------- square root ----------------
   psg_pkg::tag_type  sq_tag;
   logic [31:0]       sq_root;
   logic [2*XW:0]     sq_side;

   psg_sqrt #(
      .SIDE_W (2 * XW + 1)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_tag   (s4_tag_ff),
      .in_rad   (s4_rad_ff),
      .in_side  ({s4_wpos_ff, s4_x_ff, s4_y_ff}),
      .out_tag  (sq_tag),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   // ---------------- stage 5: total phase ----------------
   psg_pkg::tag_type     s5_tag_ff;
   logic [58:0]          s5_total_ff;
   logic [2*XW:0]        s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_tag_ff <= '0;
      end else if (en) begin
         s5_tag_ff <= sq_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_total_ff <= 59'(ds2n_ff) * 59'(sq_root);
         s5_side_ff  <= sq_side;
      end
   end

   // ---------------- stage 6: partial products by 8/pi ----------------
   psg_pkg::tag_type     s6_tag_ff;
   logic [63:0]          s6_p00_ff;
   logic [63:0]          s6_p01_ff;
   logic [58:0]          s6_p10_ff;
   logic [27:0]          s6_p11_ff;
   logic [2*XW:0]        s6_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_tag_ff <= '0;
      end else if (en) begin
         s6_tag_ff <= s5_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_p00_ff  <= 64'(s5_total_ff[31:0]) * 64'(psg_pkg::PHASE_C0);
         s6_p01_ff  <= 64'(s5_total_ff[31:0]) * 64'(psg_pkg::PHASE_C1);
         s6_p10_ff  <= 59'(s5_total_ff[58:32]) * 59'(psg_pkg::PHASE_C0);
         s6_p11_ff  <= 28'(s5_total_ff[58:32] * psg_pkg::PHASE_C1[27:0]);
         s6_side_ff <= s5_side_ff;
      end
   end

   // ---------------- stage 7: middle sum ----------------
   psg_pkg::tag_type     s7_tag_ff;
   logic [31:0]          s7_mid_ff;
   logic [27:0]          s7_p11_ff;
   logic [2*XW:0]        s7_side_ff;
   logic [63:0]          mid_sum;

   assign mid_sum = s6_p01_ff + 64'(s6_p10_ff) + 64'(s6_p00_ff[63:32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_tag_ff <= '0;
      end else if (en) begin
         s7_tag_ff <= s6_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_mid_ff  <= mid_sum[59:28];
         s7_p11_ff  <= s6_p11_ff;
         s7_side_ff <= s6_side_ff;
      end
   end

   // ---------------- stage 8: angle in turns ----------------
   psg_pkg::tag_type     s8_tag_ff;
   logic [31:0]          s8_angle_ff;
   logic signed [XW-1:0] s8_x_ff;
   logic signed [XW-1:0] s8_y_ff;
   logic [31:0]          phase_in;
   logic                 wpos7;

   assign wpos7    = s7_side_ff[2*XW];
   assign phase_in = {28'(s7_p11_ff + s7_mid_ff[31:4]), s7_mid_ff[3:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_tag_ff <= '0;
      end else if (en) begin
         s8_tag_ff <= s7_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_angle_ff <= wpos7 ? 32'(-phase_in) : phase_in;
         s8_x_ff     <= s7_side_ff[2*XW-1:XW];
         s8_y_ff     <= s7_side_ff[XW-1:0];
      end
   end

   // ---------------- stage 9: quarter-turn selection ----------------
   psg_pkg::tag_type     s9_tag_ff;
   logic signed [31:0]   s9_z_ff;
   logic signed [XW-1:0] s9_x_ff;
   logic signed [XW-1:0] s9_y_ff;
   logic [31:0]          angle_up;
   psg_pkg::quad_type    quad;
   logic signed [XW-1:0] xq_in;
   logic signed [XW-1:0] yq_in;

   assign angle_up = s8_angle_ff + 32'h2000_0000;
   assign quad     = psg_pkg::quad_type'(angle_up[31:30]);

   always_comb begin
      case (quad)
         psg_pkg::QUAD_1: begin
            xq_in = -s8_y_ff;
            yq_in = s8_x_ff;
         end
         psg_pkg::QUAD_2: begin
            xq_in = -s8_x_ff;
            yq_in = -s8_y_ff;
         end
         psg_pkg::QUAD_3: begin
            xq_in = s8_y_ff;
            yq_in = -s8_x_ff;
         end
         default: begin
            xq_in = s8_x_ff;
            yq_in = s8_y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_tag_ff <= '0;
      end else if (en) begin
         s9_tag_ff <= s8_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s9_z_ff <= $signed(s8_angle_ff - {angle_up[31:30], 30'd0});
         s9_x_ff <= xq_in;
         s9_y_ff <= yq_in;
      end
   end

   // ---------------- rotator ----------------
   psg_pkg::tag_type     rot_tag;
   logic signed [XW-1:0] rot_x;
   logic signed [XW-1:0] rot_y;

   psg_cordic #(
      .XW (XW)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_tag  (s9_tag_ff),
      .in_x    (s9_x_ff),
      .in_y    (s9_y_ff),
      .in_z    (s9_z_ff),
      .out_tag (rot_tag),
      .out_x   (rot_x),
      .out_y   (rot_y)
   );

   // ---------------- output: round and saturate ----------------
   logic signed [XW-1:0] x_bias;
   logic signed [XW-1:0] y_bias;
   logic signed [RW-1:0] x_rnd;
   logic signed [RW-1:0] y_rnd;
   logic signed [SB-1:0] re_in;
   logic signed [SB-1:0] im_in;
   logic signed [SB-1:0] rsp_re_ff;
   logic signed [SB-1:0] rsp_im_ff;
   logic                 rsp_evan_ff;

   assign x_bias = rot_x + XW'(1 << 21);
   assign y_bias = rot_y + XW'(1 << 21);
   assign x_rnd  = x_bias[XW-1:22];
   assign y_rnd  = y_bias[XW-1:22];

   always_comb begin
      if (x_rnd[RW-1:SB-1] == '0 || x_rnd[RW-1:SB-1] == '1) begin
         re_in = x_rnd[SB-1:0];
      end else begin
         re_in = x_rnd[RW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end
      if (y_rnd[RW-1:SB-1] == '0 || y_rnd[RW-1:SB-1] == '1) begin
         im_in = y_rnd[SB-1:0];
      end else begin
         im_in = y_rnd[RW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end
      if (rot_tag.evan) begin
         re_in = '0;
         im_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rot_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_re_ff   <= re_in;
         rsp_im_ff   <= im_in;
         rsp_evan_ff <= rot_tag.evan;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_green_re   = rsp_re_ff;
   assign rsp_green_im   = rsp_im_ff;
   assign rsp_evanescent = rsp_evan_ff;

   // ---------------- assertions ----------------
   a_evan_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_evan_ff |-> (rsp_re_ff == '0) && (rsp_im_ff == '0))
      else $error("evanescent word carries a nonzero sample");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(s8_angle_ff) && $stable(s8_tag_ff))
      else $error("pipeline moved while the result was stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_tag_ff.valid)
      else $error("valid bits not cleared by reset");

endmodule
